// File: rtl/core/mbw_pkg.sv
package mbw_pkg;

  // field widths fixed by the interface
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_BITS_W = 6;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned PAD_W      = 3;
  localparam int unsigned PART_W     = 7;

  localparam logic [CFG_W-1:0]   MAX_BYTES_RESET = 20'hFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 21'h1FFFFF;

  // depth of the job queue and of the result queue
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_PUT   = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

  // per-job control handed from front to back
  typedef struct packed {
    logic             is_close;
    logic             byte_valid;
    logic [PAD_W-1:0] pad;
  } job_ctl_t;

  // one result item
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last;
    logic [PAD_W-1:0] pad_bits;
    logic             overflow;
  } res_t;

endpackage

// File: rtl/core/mbw_fifo.sv
module mbw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/mbw_front.sv
module mbw_front #(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  operation_i,
  input  logic [mbw_pkg::VALUE_W-1:0]           value_i,
  input  logic [mbw_pkg::NUM_BITS_W-1:0]        num_bits_i,
  output logic                                  job_push_o,
  output mbw_pkg::job_ctl_t                     job_ctl_o,
  output logic [$clog2(((MAX_FIELD_BITS < 63) ? MAX_FIELD_BITS : 63) / 8 + 1 + 1)-1:0]
                                                job_cnt_o,
  output logic [8*((((MAX_FIELD_BITS < 63) ? MAX_FIELD_BITS : 63) + 7) / 8)-1:0]
                                                job_buf_o
);

  localparam int unsigned NMAX = (MAX_FIELD_BITS < 63) ? MAX_FIELD_BITS : 63;
  localparam int unsigned MAXB = (NMAX + 7) / 8;
  localparam int unsigned BW   = 8 * MAXB;
  localparam int unsigned CNTW = $clog2(NMAX / 8 + 1 + 1);
  localparam int unsigned FWX  = (NMAX > 32) ? NMAX : 32;
  localparam int unsigned CW   = BW + 8;
  localparam int unsigned TW   = $clog2(CW + 1);

  logic [mbw_pkg::PART_W-1:0]     partial_q, partial_d;
  logic [2:0]                     pcnt_q, pcnt_d;
  logic [mbw_pkg::NUM_BITS_W-1:0] n_c;
  logic [FWX-1:0]                 ext;
  logic [CW-1:0]                  comb_bits;
  logic [CW-1:0]                  aligned;
  logic [TW-1:0]                  total;
  logic [CNTW-1:0]                nbytes;
  logic [mbw_pkg::PAD_W-1:0]      pad;
  logic [7:0]                     close_byte;
  logic                           is_close;

  assign is_close = (mbw_pkg::op_e'(operation_i) == mbw_pkg::OP_CLOSE);

  // put: append the clamped field to the pending bits
  assign n_c       = (num_bits_i > mbw_pkg::NUM_BITS_W'(NMAX)) ?
                     mbw_pkg::NUM_BITS_W'(NMAX) : num_bits_i;
  assign ext       = FWX'(value_i) & ~({FWX{1'b1}} << n_c);
  assign comb_bits = (CW'(partial_q) << n_c) | CW'(ext);
  assign total     = TW'(pcnt_q) + TW'(n_c);
  assign nbytes    = CNTW'(total >> 3);
  // left-align the whole string so byte 0 sits on top
  assign aligned   = comb_bits << (TW'(CW) - total);

  // close: pad pending bits up to a byte
  assign pad        = mbw_pkg::PAD_W'(4'd8 - {1'b0, pcnt_q});
  assign close_byte = 8'({1'b0, partial_q} << pad);

  // job build
  always_comb begin
    partial_d  = partial_q;
    pcnt_d     = pcnt_q;
    job_push_o = 1'b0;
    job_ctl_o  = '0;
    job_cnt_o  = nbytes;
    job_buf_o  = aligned[CW-1 -: BW];
    if (is_close) begin
      job_ctl_o.is_close   = 1'b1;
      job_ctl_o.byte_valid = (pcnt_q != 3'd0);
      job_ctl_o.pad        = (pcnt_q != 3'd0) ? pad : '0;
      job_cnt_o            = CNTW'(1);
      job_buf_o            = BW'(close_byte) << (BW - 8);
      job_push_o           = accept_i;
      if (accept_i) begin
        partial_d = '0;
        pcnt_d    = '0;
      end
    end else begin
      job_ctl_o.byte_valid = 1'b1;
      job_push_o           = accept_i && (nbytes != '0);
      if (accept_i) begin
        pcnt_d    = total[2:0];
        partial_d = mbw_pkg::PART_W'(comb_bits & ~({CW{1'b1}} << total[2:0]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pcnt_q    <= '0;
    end else begin
      partial_q <= partial_d;
      pcnt_q    <= pcnt_d;
    end
  end

endmodule

// File: rtl/core/mbw_back.sv
module mbw_back #(
  parameter int unsigned BUF_BYTES = 4,
  parameter int unsigned CNT_W     = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mbw_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         job_empty_i,
  input  mbw_pkg::job_ctl_t            job_ctl_i,
  input  logic [CNT_W-1:0]             job_cnt_i,
  input  logic [8*BUF_BYTES-1:0]       job_buf_i,
  output logic                         job_pop_o,
  input  logic                         res_full_i,
  output logic                         res_push_o,
  output mbw_pkg::res_t                res_o
);

  localparam int unsigned BW = 8 * BUF_BYTES;

  logic [mbw_pkg::CFG_W-1:0]   max_bytes_q;
  logic [mbw_pkg::COUNT_W-1:0] bw_q, bw_d;
  logic                        wvalid_q, wvalid_d;
  mbw_pkg::job_ctl_t           wctl_q, wctl_d;
  logic [CNT_W-1:0]            wcnt_q, wcnt_d;
  logic [BW-1:0]               wbuf_q, wbuf_d;
  logic                        emit, finishing, load;

  assign emit       = wvalid_q && !res_full_i;
  assign finishing  = emit && (wcnt_q == CNT_W'(1));
  assign load       = !job_empty_i && (!wvalid_q || finishing);
  assign job_pop_o  = load;
  assign res_push_o = emit;

  // result fields from the head byte of the working job
  always_comb begin
    res_o            = '0;
    res_o.out_byte   = wbuf_q[BW-1 -: 8];
    res_o.byte_valid = wctl_q.byte_valid;
    res_o.last       = (wcnt_q == CNT_W'(1));
    res_o.pad_bits   = wctl_q.pad;
    res_o.overflow   = wctl_q.byte_valid && (bw_q >= {1'b0, max_bytes_q});
  end

  // byte count: saturating, cleared by a close
  always_comb begin
    bw_d = bw_q;
    if (emit) begin
      if (wctl_q.is_close) begin
        bw_d = '0;
      end else if (bw_q != mbw_pkg::COUNT_MAX) begin
        bw_d = bw_q + mbw_pkg::COUNT_W'(1);
      end
    end
  end

  // working job: shift out one byte per transfer, reload from the queue
  always_comb begin
    wvalid_d = wvalid_q;
    wctl_d   = wctl_q;
    wcnt_d   = wcnt_q;
    wbuf_d   = wbuf_q;
    if (emit) begin
      wcnt_d = wcnt_q - CNT_W'(1);
      wbuf_d = wbuf_q << 8;
    end
    if (finishing) begin
      wvalid_d = 1'b0;
    end
    if (load) begin
      wvalid_d = 1'b1;
      wctl_d   = job_ctl_i;
      wcnt_d   = job_cnt_i;
      wbuf_d   = job_buf_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= mbw_pkg::MAX_BYTES_RESET;
      bw_q        <= '0;
      wvalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_data_i;
      end
      bw_q     <= bw_d;
      wvalid_q <= wvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wctl_q <= wctl_d;
    wcnt_q <= wcnt_d;
    wbuf_q <= wbuf_d;
  end

endmodule

// File: rtl/core/msb_first_bit_writer_top.sv
// a result passes through the job queue, the back's working job and the result queue to the output ports
// throughput: one item per cycle into the front while the job queue has room
// the back delivers one byte per cycle while the result queue has room, so a put
// with k bytes holds it until all k bytes are out, and a close until its one result is out
// reset: pending bits, byte count and both queues clear at once, max_bytes
// returns to 1048575
module msb_first_bit_writer_top #(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbw_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           operation_i,
  input  logic [mbw_pkg::VALUE_W-1:0]    value_i,
  input  logic [mbw_pkg::NUM_BITS_W-1:0] num_bits_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           last_o,
  output logic [mbw_pkg::PAD_W-1:0]      pad_bits_o,
  output logic                           overflow_o
);

  localparam int unsigned NMAX  = (MAX_FIELD_BITS < 63) ? MAX_FIELD_BITS : 63;
  localparam int unsigned MAXB  = (NMAX + 7) / 8;
  localparam int unsigned BW    = 8 * MAXB;
  localparam int unsigned CNTW  = $clog2(NMAX / 8 + 1 + 1);
  localparam int unsigned CTLW  = $bits(mbw_pkg::job_ctl_t);
  localparam int unsigned JOB_W = CTLW + CNTW + BW;
  localparam int unsigned RES_W = $bits(mbw_pkg::res_t);

  logic              in_xfer;
  logic              jq_push, jq_full, jq_pop, jq_empty;
  mbw_pkg::job_ctl_t f_ctl, b_ctl;
  logic [CNTW-1:0]   f_cnt, b_cnt;
  logic [BW-1:0]     f_buf, b_buf;
  logic [JOB_W-1:0]  jq_rdata;
  logic              rq_push, rq_full;
  mbw_pkg::res_t     b_res, o_res;
  logic [RES_W-1:0]  rq_rdata;

  assign cfg_ready_o = 1'b1;
  assign full        = jq_full;
  assign in_xfer     = push && !jq_full;

  // front: classify and pack items into jobs
  mbw_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .operation_i(operation_i),
    .value_i    (value_i),
    .num_bits_i (num_bits_i),
    .job_push_o (jq_push),
    .job_ctl_o  (f_ctl),
    .job_cnt_o  (f_cnt),
    .job_buf_o  (f_buf)
  );

  // job queue between front and back
  mbw_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(mbw_pkg::QUEUE_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (jq_push),
    .data_i ({f_ctl, f_cnt, f_buf}),
    .full_o (jq_full),
    .pop_i  (jq_pop),
    .data_o (jq_rdata),
    .empty_o(jq_empty)
  );

  assign b_ctl = mbw_pkg::job_ctl_t'(jq_rdata[JOB_W-1 -: CTLW]);
  assign b_cnt = jq_rdata[BW +: CNTW];
  assign b_buf = jq_rdata[BW-1:0];

  // back: emit bytes and track the stream count
  mbw_back #(
    .BUF_BYTES(MAXB),
    .CNT_W    (CNTW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .job_empty_i(jq_empty),
    .job_ctl_i  (b_ctl),
    .job_cnt_i  (b_cnt),
    .job_buf_i  (b_buf),
    .job_pop_o  (jq_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_o      (b_res)
  );

  // result queue toward the consumer
  mbw_fifo #(
    .WIDTH(RES_W),
    .DEPTH(mbw_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rq_push),
    .data_i (b_res),
    .full_o (rq_full),
    .pop_i  (pop),
    .data_o (rq_rdata),
    .empty_o(empty)
  );

  assign o_res        = mbw_pkg::res_t'(rq_rdata);
  assign out_byte_o   = o_res.out_byte;
  assign byte_valid_o = o_res.byte_valid;
  assign last_o       = o_res.last;
  assign pad_bits_o   = o_res.pad_bits;
  assign overflow_o   = o_res.overflow;

endmodule

// File: bench/tb_msb_first_bit_writer_top.sv
`timescale 1ns / 1ps

module tb_msb_first_bit_writer_top;

  localparam int unsigned FIELD_LIMIT = 32;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned STALL_LIMIT = 2000;

  // expected byte stream, kept in step with every accepted put or close
  class packer_scoreboard;
    int unsigned                 field_limit;
    logic [mbw_pkg::CFG_W-1:0]   max_bytes;
    logic [6:0]                  partial_bits;
    logic [2:0]                  partial_cnt;
    logic [mbw_pkg::COUNT_W-1:0] stream_bytes;
    mbw_pkg::res_t               expected_bytes[$];
    int unsigned                 mismatches, checked, ovf_seen;
    int unsigned                 n_puts, n_closes, n_empty_closes, n_clamped;

    function new(int unsigned limit);
      field_limit  = limit;
      max_bytes    = mbw_pkg::MAX_BYTES_RESET;
      partial_bits = '0;
      partial_cnt  = '0;
      stream_bytes = '0;
    endfunction

    // one predicted result, with overflow judged on the byte's stream index
    function void add_byte(logic [7:0] data, logic valid,
                           logic [mbw_pkg::PAD_W-1:0] pad);
      mbw_pkg::res_t r;
      r.out_byte   = data;
      r.byte_valid = valid;
      r.last       = 1'b0;
      r.pad_bits   = pad;
      r.overflow   = valid && (stream_bytes >= {1'b0, max_bytes});
      if (valid && stream_bytes != mbw_pkg::COUNT_MAX) stream_bytes++;
      expected_bytes.push_back(r);
    endfunction

    // predict the results of one accepted item
    function void note_item(mbw_pkg::op_e op, logic [mbw_pkg::VALUE_W-1:0] v,
                            logic [mbw_pkg::NUM_BITS_W-1:0] n);
      int unsigned width;
      int unsigned fill;
      int unsigned pad;
      int          first;
      logic [7:0]  acc;
      first = expected_bytes.size();
      if (op == mbw_pkg::OP_PUT) begin
        n_puts++;
        width = (n > field_limit) ? field_limit : n;
        if (n > field_limit) n_clamped++;
        acc  = {1'b0, partial_bits};
        fill = partial_cnt;
        // shift in the field, oldest bit first
        for (int i = int'(width) - 1; i >= 0; i--) begin
          acc = {acc[6:0], (i < 32) ? v[i] : 1'b0};
          fill++;
          if (fill == 8) begin
            add_byte(acc, 1'b1, '0);
            acc  = '0;
            fill = 0;
          end
        end
        partial_bits = acc[6:0];
        partial_cnt  = fill[2:0];
        if (expected_bytes.size() > first)
          expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      end else begin
        n_closes++;
        if (partial_cnt != 0) begin
          pad = 8 - partial_cnt;
          acc = {1'b0, partial_bits} << pad;
          add_byte(acc, 1'b1, pad[mbw_pkg::PAD_W-1:0]);
        end else begin
          n_empty_closes++;
          add_byte('0, 1'b0, '0);
        end
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        // a close starts a fresh stream
        partial_bits = '0;
        partial_cnt  = '0;
        stream_bytes = '0;
      end
    endfunction

    // compare one popped result with the oldest prediction
    function void check_byte(mbw_pkg::res_t got);
      mbw_pkg::res_t want;
      if (expected_bytes.size() == 0) begin
        $error("result with nothing pending: out_byte %0h", got.out_byte);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got.overflow === 1'b1) ovf_seen++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid expected %0d actual %0d", want.byte_valid, got.byte_valid);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        mismatches++;
      end
      if (got.pad_bits !== want.pad_bits) begin
        $error("pad_bits expected %0d actual %0d", want.pad_bits, got.pad_bits);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [mbw_pkg::CFG_W-1:0]      cfg_data_i;
  logic                           push;
  logic                           full;
  logic                           operation_i;
  logic [mbw_pkg::VALUE_W-1:0]    value_i;
  logic [mbw_pkg::NUM_BITS_W-1:0] num_bits_i;
  logic                           empty;
  logic                           pop;
  logic [7:0]                     out_byte_o;
  logic                           byte_valid_o;
  logic                           last_o;
  logic [mbw_pkg::PAD_W-1:0]      pad_bits_o;
  logic                           overflow_o;

  packer_scoreboard sb = new(FIELD_LIMIT);
  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  int unsigned idle_cycles;

  msb_first_bit_writer_top #(
    .MAX_FIELD_BITS(FIELD_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .num_bits_i   (num_bits_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .pad_bits_o   (pad_bits_o),
    .overflow_o   (overflow_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side: random stalls, check every transfer
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        sb.check_byte('{out_byte: out_byte_o, byte_valid: byte_valid_o, last: last_o,
                        pad_bits: pad_bits_o, overflow: overflow_o});
      pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item, leave push high after the transfer
  task automatic send_item(mbw_pkg::op_e op, logic [mbw_pkg::VALUE_W-1:0] v,
                           logic [mbw_pkg::NUM_BITS_W-1:0] n);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    num_bits_i  <= n;
    do @(posedge clk_i); while (full);
    sb.note_item(op, v, n);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    push <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // capacity register write, only with the block idle
  task automatic write_max_bytes(logic [mbw_pkg::CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.max_bytes = v;
  endtask

  // random puts and closes, mostly ordinary widths
  task automatic send_random(int unsigned count);
    int unsigned                    pick;
    logic [mbw_pkg::NUM_BITS_W-1:0] n;
    logic [mbw_pkg::VALUE_W-1:0]    v;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(39) == 0) drain();
      pick = $urandom_range(99);
      if (pick < 8)       v = '0;
      else if (pick < 16) v = '1;
      else                v = $urandom();
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(mbw_pkg::OP_CLOSE, v, mbw_pkg::NUM_BITS_W'($urandom_range(63)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 8)       n = '0;
        else if (pick < 18) n = mbw_pkg::NUM_BITS_W'($urandom_range(63, 33));
        else if (pick < 30) n = mbw_pkg::NUM_BITS_W'(32);
        else                n = mbw_pkg::NUM_BITS_W'($urandom_range(31, 1));
        send_item(mbw_pkg::OP_PUT, v, n);
      end
    end
  endtask

  // one setting of capacity and idling, then random traffic
  task automatic run_phase(logic [mbw_pkg::CFG_W-1:0] cap, int unsigned s_pct,
                           int unsigned p_pct, int unsigned count);
    drain();
    write_max_bytes(cap);
    send_idle_pct = s_pct;
    pop_stall_pct = p_pct;
    send_random(count);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    operation_i   <= mbw_pkg::OP_PUT;
    value_i       <= '0;
    num_bits_i    <= '0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: widest capacity, no idling
    write_max_bytes(20'hFFFFF);
    send_item(mbw_pkg::OP_CLOSE, '1, '1);                 // close with nothing pending
    send_item(mbw_pkg::OP_PUT, '0, '0);                   // zero width
    send_item(mbw_pkg::OP_PUT, '1, '0);
    send_item(mbw_pkg::OP_PUT, 32'h1, 6'd1);
    send_item(mbw_pkg::OP_CLOSE, '0, '0);                 // seven pad bits
    send_item(mbw_pkg::OP_PUT, '1, 6'd7);
    send_item(mbw_pkg::OP_CLOSE, '0, '0);                 // one pad bit
    send_item(mbw_pkg::OP_PUT, 32'hA5, 6'd8);
    send_item(mbw_pkg::OP_PUT, '1, 6'd32);                // four bytes at once
    send_item(mbw_pkg::OP_PUT, '0, 6'd32);
    send_item(mbw_pkg::OP_PUT, 32'h1234_5678, 6'd33);     // clamped width
    send_item(mbw_pkg::OP_PUT, '1, 6'd63);
    send_item(mbw_pkg::OP_PUT, 32'h3, 6'd3);
    send_item(mbw_pkg::OP_PUT, 32'h8000_0000, 6'd32);     // field straddles bytes
    send_item(mbw_pkg::OP_PUT, 32'h5, 6'd5);
    send_item(mbw_pkg::OP_CLOSE, '0, '0);
    send_item(mbw_pkg::OP_PUT, 32'h2, 6'd2);
    send_item(mbw_pkg::OP_CLOSE, '0, '0);
    send_item(mbw_pkg::OP_PUT, 32'h3F, 6'd6);
    send_item(mbw_pkg::OP_PUT, 32'h1, 6'd1);
    send_item(mbw_pkg::OP_PUT, 32'hFFFF_FFFE, 6'd31);
    send_item(mbw_pkg::OP_CLOSE, '1, '0);

    run_phase(20'h00000, 56, 0, 50);
    run_phase(20'd3, 0, 56, 50);
    run_phase(mbw_pkg::CFG_W'($urandom_range(24, 1)), 37, 37, 50);
    run_phase(20'd9, 0, 0, 50);

    drain();
    $display("covered %0d puts (%0d clamped) and %0d closes (%0d empty) over five capacities",
             sb.n_puts, sb.n_clamped, sb.n_closes, sb.n_empty_closes);
    $display("checked %0d results, %0d flagged overflow, %0d mismatches",
             sb.checked, sb.ovf_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
